// File: hw/rtl/lfid_pkg.sv
// Shared types, constants and helper functions for the lowest-free ID allocator map.
// No dependencies; every other file refers to it by scoped names.
package lfid_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ID_W      = $clog2(CAPACITY);
  localparam int CNT_W     = ID_W + 1;
  localparam int COL_W     = 5;
  localparam int ROW_W     = ID_W - COL_W;
  localparam int ROWS      = CAPACITY / (1 << COL_W);
  localparam int COLS      = 1 << COL_W;
  localparam int COMP_W    = 16;
  localparam int LOCAL_W   = 32;
  localparam int RANGE_W   = 7;
  localparam int MAX_RANGE = 64;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_RECLAIM = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;
  localparam logic [1:0] CMD_LOOKUP  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_OCCUPIED = 3'd2;
  localparam logic [2:0] ST_FREE     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [COMP_W-1:0]  INVALID_COMP  = '1;
  localparam logic [LOCAL_W-1:0] INVALID_LOCAL = '1;

  typedef struct packed {
    logic [1:0]         command;
    logic [ID_W-1:0]    target_id;
    logic [COMP_W-1:0]  component;
    logic [LOCAL_W-1:0] local_index;
    logic [RANGE_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    result_id;
    logic [COMP_W-1:0]  result_component;
    logic [LOCAL_W-1:0] result_local;
    logic [2:0]         status;
    logic               last;
    logic [CNT_W-1:0]   used_count;
    logic [CNT_W-1:0]   free_count;
  } out_item_t;

  function automatic logic [COL_W-1:0] first_set(input logic [COLS-1:0] v);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = COLS - 1; i >= 0; i--) begin
      if (v[i]) idx = i[COL_W-1:0];
    end
    return idx;
  endfunction

endpackage

// File: hw/rtl/lfid_front.sv
// Command front end: accepts transactions, saturates insert counts, drops empty inserts.
// Depends on lfid_pkg.
module lfid_front (
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lfid_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output lfid_pkg::in_item_t q_data
);

  logic is_insert;

  assign busy      = q_full;
  assign is_insert = (in_data.command == lfid_pkg::CMD_INSERT);

  always_comb begin
    q_data = in_data;
    if (is_insert && (in_data.count > lfid_pkg::RANGE_W'(lfid_pkg::MAX_RANGE))) begin
      q_data.count = lfid_pkg::RANGE_W'(lfid_pkg::MAX_RANGE);
    end
  end

  // drop an insert of zero entries: it yields no transaction
  assign q_push = start && !q_full && rst_n && !(is_insert && (in_data.count == '0));

endmodule

// File: hw/rtl/lfid_queue.sv
// Two-entry command queue between the front end and the execution engine.
// Depends on lfid_pkg.
module lfid_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lfid_pkg::in_item_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               valid,
  output lfid_pkg::in_item_t head
);

  lfid_pkg::in_item_t slot_r [2];
  logic [1:0]         cnt_r;
  logic               rd_r;
  logic               wr_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

endmodule

// File: hw/rtl/lfid_engine.sv
// Execution engine: ID tables, free bitmap with row summary, lowest-free search.
// Depends on lfid_pkg.
module lfid_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lfid_pkg::in_item_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  output lfid_pkg::out_item_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_FIND  = 5'b00100,
    S_READ  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  localparam int ID_W    = lfid_pkg::ID_W;
  localparam int CNT_W   = lfid_pkg::CNT_W;
  localparam int COL_W   = lfid_pkg::COL_W;
  localparam int ROW_W   = lfid_pkg::ROW_W;
  localparam int COLS    = lfid_pkg::COLS;
  localparam int ROWS    = lfid_pkg::ROWS;
  localparam int COMP_W  = lfid_pkg::COMP_W;
  localparam int LOCAL_W = lfid_pkg::LOCAL_W;

  state_t state_r, state_nxt;
  lfid_pkg::in_item_t item_r, item_nxt;
  logic [lfid_pkg::RANGE_W-1:0] cnt_r, cnt_nxt;
  logic [LOCAL_W-1:0] loc_r, loc_nxt;
  logic [CNT_W-1:0]   hw_r, hw_nxt, ft_r, ft_nxt;
  logic [ROWS-1:0]    sum_r, sum_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic [COMP_W-1:0]  comp_mem [lfid_pkg::CAPACITY];
  logic [LOCAL_W-1:0] loc_mem  [lfid_pkg::CAPACITY];
  logic [COLS-1:0]    fm_mem   [ROWS];
  logic [COMP_W-1:0]  comp_q;
  logic [LOCAL_W-1:0] loc_q;
  logic [COLS-1:0]    fm_q;

  logic               tbl_we;
  logic [ID_W-1:0]    tbl_waddr;
  logic [COMP_W-1:0]  tbl_wcomp;
  logic [LOCAL_W-1:0] tbl_wloc;
  logic               fm_we;
  logic [ROW_W-1:0]   fm_addr;
  logic [COLS-1:0]    fm_wdata;

  logic               emit;
  lfid_pkg::out_item_t emit_data;
  logic               out_valid_r;
  lfid_pkg::out_item_t out_r;

  logic [ROW_W-1:0]   g_row;
  logic [COL_W-1:0]   g_col, f_col;
  logic [COLS-1:0]    word, new_word;
  logic               alloc;
  logic [ID_W-1:0]    alloc_id;

  assign g_row = item_r.target_id[ID_W-1:COL_W];
  assign g_col = item_r.target_id[COL_W-1:0];

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    loc_nxt   = loc_r;
    hw_nxt    = hw_r;
    ft_nxt    = ft_r;
    sum_nxt   = sum_r;
    row_nxt   = row_r;
    q_pop     = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = item_r.target_id;
    tbl_wcomp = item_r.component;
    tbl_wloc  = item_r.local_index;
    fm_we     = 1'b0;
    fm_addr   = g_row;
    fm_wdata  = '0;
    emit      = 1'b0;
    emit_data = '0;
    alloc     = 1'b0;
    alloc_id  = '0;
    word      = sum_r[g_row] ? fm_q : '0;
    f_col     = lfid_pkg::first_set(fm_q);
    new_word  = word;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_head;
          cnt_nxt  = q_head.count;
          loc_nxt  = q_head.local_index;
          state_nxt = (q_head.command == lfid_pkg::CMD_INSERT) ? S_ALLOC : S_READ;
        end
      end
      S_ALLOC: begin
        row_nxt = ROW_W'(lfid_pkg::first_set(sum_r));
        fm_addr = row_nxt;
        if (ft_r != '0) begin
          state_nxt = S_FIND;
        end else if (hw_r < CNT_W'(lfid_pkg::CAPACITY)) begin
          alloc    = 1'b1;
          alloc_id = hw_r[ID_W-1:0];
          hw_nxt   = hw_r + CNT_W'(1);
        end else begin
          emit             = 1'b1;
          emit_data.status = lfid_pkg::ST_FULL;
          emit_data.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_FIND: begin
        // row summary was set, so the bitmap word is valid
        new_word        = fm_q;
        new_word[f_col] = 1'b0;
        fm_we           = 1'b1;
        fm_addr         = row_r;
        fm_wdata        = new_word;
        sum_nxt[row_r]  = |new_word;
        ft_nxt          = ft_r - CNT_W'(1);
        alloc           = 1'b1;
        alloc_id        = {row_r, f_col};
      end
      S_READ: begin
        if ({1'b0, item_r.target_id} >= hw_r) begin
          emit                       = 1'b1;
          emit_data.result_id        = item_r.target_id;
          emit_data.result_component = lfid_pkg::INVALID_COMP;
          emit_data.result_local     = lfid_pkg::INVALID_LOCAL;
          emit_data.status           = lfid_pkg::ST_RANGE;
          emit_data.last             = 1'b1;
          state_nxt                  = S_IDLE;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        emit                       = 1'b1;
        emit_data.result_id        = item_r.target_id;
        emit_data.result_component = comp_q;
        emit_data.result_local     = loc_q;
        emit_data.status           = lfid_pkg::ST_OK;
        emit_data.last             = 1'b1;
        state_nxt                  = S_IDLE;
        case (item_r.command)
          lfid_pkg::CMD_RECLAIM: begin
            if (word[g_col]) begin
              new_word[g_col] = 1'b0;
              fm_we           = 1'b1;
              fm_wdata        = new_word;
              sum_nxt[g_row]  = |new_word;
              ft_nxt          = ft_r - CNT_W'(1);
              tbl_we          = 1'b1;
              emit_data.result_component = item_r.component;
              emit_data.result_local     = item_r.local_index;
            end else begin
              emit_data.status = lfid_pkg::ST_OCCUPIED;
            end
          end
          lfid_pkg::CMD_REMOVE: begin
            if (comp_q == lfid_pkg::INVALID_COMP && loc_q == lfid_pkg::INVALID_LOCAL) begin
              emit_data.status = lfid_pkg::ST_FREE;
            end else begin
              tbl_we    = 1'b1;
              tbl_wcomp = lfid_pkg::INVALID_COMP;
              tbl_wloc  = lfid_pkg::INVALID_LOCAL;
              emit_data.result_component = lfid_pkg::INVALID_COMP;
              emit_data.result_local     = lfid_pkg::INVALID_LOCAL;
              if (!word[g_col]) begin
                new_word[g_col] = 1'b1;
                fm_we           = 1'b1;
                fm_wdata        = new_word;
                sum_nxt[g_row]  = 1'b1;
                ft_nxt          = ft_r + CNT_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase

    if (alloc) begin
      tbl_we    = 1'b1;
      tbl_waddr = alloc_id;
      tbl_wloc  = loc_r;
      emit      = 1'b1;
      emit_data.result_id        = alloc_id;
      emit_data.result_component = item_r.component;
      emit_data.result_local     = loc_r;
      emit_data.status           = lfid_pkg::ST_OK;
      emit_data.last             = (cnt_r == lfid_pkg::RANGE_W'(1));
      cnt_nxt   = cnt_r - lfid_pkg::RANGE_W'(1);
      loc_nxt   = loc_r + LOCAL_W'(1);
      state_nxt = (cnt_r == lfid_pkg::RANGE_W'(1)) ? S_IDLE : S_ALLOC;
    end
    emit_data.used_count = hw_nxt;
    emit_data.free_count = ft_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      ft_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      ft_r        <= ft_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    cnt_r  <= cnt_nxt;
    loc_r  <= loc_nxt;
    row_r  <= row_nxt;
    out_r  <= emit_data;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      comp_mem[tbl_waddr] <= tbl_wcomp;
      loc_mem[tbl_waddr]  <= tbl_wloc;
    end
    comp_q <= comp_mem[item_r.target_id];
    loc_q  <= loc_mem[item_r.target_id];
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_addr] <= fm_wdata;
    fm_q <= fm_mem[fm_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/lowest_free_id_allocator_map.sv
// Top level of the lowest-free ID allocator map: front end, command queue, engine.
// Depends on lfid_pkg, lfid_front, lfid_queue and lfid_engine.
//
// A command is taken when start is high and busy is low; busy rises only while the
// two-entry command queue is full. Each result shows on out_data for one cycle with
// out_valid high and cannot be held off. Lookup, reclaim and remove go through queue pop,
// table and bitmap read, and update; an out-of-range id ends at the read. An insert of
// n entries pops the queue, then appends each entry at the high-water mark in S_ALLOC and
// reuses a freed id via S_ALLOC and S_FIND, since the free bitmap is kept as 32-bit rows
// in a memory behind a row summary and each reuse reads one row. No clearing pass after
// reset: the row summary is cleared at once.
module lowest_free_id_allocator_map (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lfid_pkg::in_item_t  in_data,
  output logic                out_valid,
  output lfid_pkg::out_item_t out_data
);

  logic               q_full, q_push, q_pop, q_valid;
  lfid_pkg::in_item_t q_in, q_head;

  lfid_front u_front (
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  lfid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  lfid_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/lfid_checker.sv
// Port-level checks for the allocator map, bound to the top level.
// Depends on lfid_pkg and lowest_free_id_allocator_map.
module lfid_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input lfid_pkg::out_item_t out_data
);

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == lfid_pkg::ST_FULL |-> out_data.last &&
      out_data.used_count == lfid_pkg::CNT_W'(lfid_pkg::CAPACITY))
    else $error("full result without last or below capacity");

  a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_count <= out_data.used_count)
    else $error("free count exceeds used count");

  a_ok_id_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == lfid_pkg::ST_OK |->
      {1'b0, out_data.result_id} < out_data.used_count)
    else $error("ok result id not below high-water mark");

endmodule

bind lowest_free_id_allocator_map lfid_checker u_lfid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);
